// ===== hdl/kefr_pkg.sv =====
`default_nettype none

package kefr_pkg;

    // Ring geometry
    localparam int QUEUE_DEPTH = 32;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int FILL_W      = 5;

    // Configuration port geometry
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Register reset values
    localparam logic [15:0] GAP_NORMAL_RST = 16'd15;
    localparam logic [15:0] GAP_FAST_RST   = 16'd2;
    localparam logic [15:0] REL_NORMAL_RST = 16'd10;
    localparam logic [15:0] REL_FAST_RST   = 16'd2;
    localparam logic [31:0] BACKSPACE_RST  = 32'd8;
    localparam logic [31:0] DELETE_RST     = 32'd127;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_READ_GAP_NORMAL      = 3'd0,
        CFG_READ_GAP_FAST        = 3'd1,
        CFG_RELEASE_AFTER_NORMAL = 3'd2,
        CFG_RELEASE_AFTER_FAST   = 3'd3,
        CFG_BACKSPACE_CODE       = 3'd4,
        CFG_DELETE_CODE          = 3'd5
    } kefr_cfg_idx_t;

    // Item actions
    typedef enum logic {
        ACT_PUSH = 1'b0,
        ACT_READ = 1'b1
    } kefr_action_t;

    // Controller states
    typedef enum logic {
        ST_IDLE,
        ST_READ
    } kefr_state_t;

    typedef struct packed {
        logic        action;
        logic [31:0] key_code;
        logic        key_pressed;
        logic [31:0] now_ms;
    } kefr_in_t;

    typedef struct packed {
        logic [31:0]       out_key;
        logic              out_pressed;
        logic              took_event;
        logic              dropped_oldest;
        logic [FILL_W-1:0] fill_level;
    } kefr_out_t;

    typedef struct packed {
        logic [15:0] read_gap_normal;
        logic [15:0] read_gap_fast;
        logic [15:0] release_after_normal;
        logic [15:0] release_after_fast;
        logic [31:0] backspace_code;
        logic [31:0] delete_code;
    } kefr_cfg_t;

    // Controller commands to the datapath
    typedef struct packed {
        logic push;
        logic rd_start;
        logic rd_finish;
    } kefr_cmd_t;

    // One ring slot
    typedef struct packed {
        logic [31:0] key;
        logic        pressed;
        logic [31:0] stamp;
    } kefr_entry_t;

endpackage

`default_nettype wire

// ===== hdl/kefr_cfg.sv =====
`default_nettype none

module kefr_cfg (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [kefr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [kefr_pkg::CFG_DATA_W-1:0]  cfg_data,
    output kefr_pkg::kefr_cfg_t                   cfg
);

    kefr_pkg::kefr_cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Decode register writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.read_gap_normal      <= kefr_pkg::GAP_NORMAL_RST;
            cfg_reg.read_gap_fast        <= kefr_pkg::GAP_FAST_RST;
            cfg_reg.release_after_normal <= kefr_pkg::REL_NORMAL_RST;
            cfg_reg.release_after_fast   <= kefr_pkg::REL_FAST_RST;
            cfg_reg.backspace_code       <= kefr_pkg::BACKSPACE_RST;
            cfg_reg.delete_code          <= kefr_pkg::DELETE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (kefr_pkg::kefr_cfg_idx_t'(cfg_index))
                kefr_pkg::CFG_READ_GAP_NORMAL:
                    cfg_reg.read_gap_normal <= cfg_data[15:0];
                kefr_pkg::CFG_READ_GAP_FAST:
                    cfg_reg.read_gap_fast <= cfg_data[15:0];
                kefr_pkg::CFG_RELEASE_AFTER_NORMAL:
                    cfg_reg.release_after_normal <= cfg_data[15:0];
                kefr_pkg::CFG_RELEASE_AFTER_FAST:
                    cfg_reg.release_after_fast <= cfg_data[15:0];
                kefr_pkg::CFG_BACKSPACE_CODE:
                    cfg_reg.backspace_code <= cfg_data[31:0];
                kefr_pkg::CFG_DELETE_CODE:
                    cfg_reg.delete_code <= cfg_data[31:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hdl/kefr_ctrl.sv =====
`default_nettype none

module kefr_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic             action,
    output logic                  busy,
    output logic                  done,
    output kefr_pkg::kefr_cmd_t   cmd
);

    kefr_pkg::kefr_state_t state_reg;
    kefr_pkg::kefr_state_t state_next;
    logic                  done_reg;
    logic                  done_next;

    // State and strobe registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= kefr_pkg::ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next    = state_reg;
        cmd.push      = 1'b0;
        cmd.rd_start  = 1'b0;
        cmd.rd_finish = 1'b0;
        busy          = 1'b0;
        unique case (state_reg)
            kefr_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    if (action == kefr_pkg::ACT_READ)
                    begin
                        cmd.rd_start = 1'b1;
                        state_next   = kefr_pkg::ST_READ;
                    end
                    else
                    begin
                        cmd.push = 1'b1;
                    end
                end
            end
            kefr_pkg::ST_READ:
            begin
                busy          = 1'b1;
                cmd.rd_finish = 1'b1;
                state_next    = kefr_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = kefr_pkg::ST_IDLE;
            end
        endcase
        done_next = cmd.push | cmd.rd_finish;
    end

    assign done = done_reg;

endmodule

`default_nettype wire

// ===== hdl/kefr_dp.sv =====
`default_nettype none

module kefr_dp (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire kefr_pkg::kefr_cmd_t  cmd,
    input  wire kefr_pkg::kefr_in_t   req,
    input  wire kefr_pkg::kefr_cfg_t  cfg,
    output kefr_pkg::kefr_out_t       rsp
);

    localparam int PW = kefr_pkg::PTR_W;

    // Ring storage and registered read port
    kefr_pkg::kefr_entry_t mem [kefr_pkg::QUEUE_DEPTH];
    kefr_pkg::kefr_entry_t rd_data_reg;

    logic [PW-1:0] head_reg, head_next;
    logic [PW-1:0] tail_reg, tail_next;
    logic [31:0]   cur_key_reg, cur_key_next;
    logic          cur_pressed_reg, cur_pressed_next;
    logic [31:0]   cur_time_reg, cur_time_next;
    logic [31:0]   last_pop_reg, last_pop_next;
    logic [31:0]   now_reg;
    kefr_pkg::kefr_out_t rsp_reg, rsp_next;

    logic [PW-1:0] push_nh;
    logic          push_drop;
    logic          fast;
    logic [15:0]   gap;
    logic [15:0]   rel;
    logic          gap_ok;
    logic          nonempty;
    logic          pop;
    logic [31:0]   new_key;
    logic          new_pressed;
    logic          aged_pop;
    logic          aged_cur;
    logic          aged;

    function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
        logic [PW-1:0] r;
        if (p == PW'(kefr_pkg::QUEUE_DEPTH - 1))
            r = '0;
        else
            r = p + 1'b1;
        return r;
    endfunction

    function automatic logic [kefr_pkg::FILL_W-1:0] fill_of(
        input logic [PW-1:0] h,
        input logic [PW-1:0] t
    );
        logic [PW:0] d;
        if (h >= t)
            d = {1'b0, h} - {1'b0, t};
        else
            d = {1'b0, h} + (PW+1)'(kefr_pkg::QUEUE_DEPTH) - {1'b0, t};
        return kefr_pkg::FILL_W'(d);
    endfunction

    // Write at head on push, fetch tail slot at read start
    always_ff @(posedge clk)
    begin
        if (cmd.push)
            mem[head_reg] <= '{key: req.key_code, pressed: req.key_pressed, stamp: req.now_ms};
        if (cmd.rd_start)
            rd_data_reg <= mem[tail_reg];
    end

    // Push pointer update, dropping the oldest entry when full
    assign push_nh   = next_ptr(head_reg);
    assign push_drop = (push_nh == tail_reg);

    // Read: classify current key, decide pop, check auto-release
    assign fast     = (cur_key_reg == cfg.backspace_code) || (cur_key_reg == cfg.delete_code);
    assign gap      = fast ? cfg.read_gap_fast : cfg.read_gap_normal;
    assign rel      = fast ? cfg.release_after_fast : cfg.release_after_normal;
    assign gap_ok   = (now_reg - last_pop_reg) > {16'd0, gap};
    assign nonempty = (head_reg != tail_reg);
    assign pop      = (!cur_pressed_reg || gap_ok) && nonempty;

    assign new_key     = pop ? rd_data_reg.key : cur_key_reg;
    assign new_pressed = pop ? rd_data_reg.pressed : cur_pressed_reg;
    assign aged_pop    = (now_reg - rd_data_reg.stamp) > {16'd0, rel};
    assign aged_cur    = (now_reg - cur_time_reg) > {16'd0, rel};
    assign aged        = pop ? aged_pop : aged_cur;

    always_comb
    begin
        head_next        = head_reg;
        tail_next        = tail_reg;
        cur_key_next     = cur_key_reg;
        cur_pressed_next = cur_pressed_reg;
        cur_time_next    = cur_time_reg;
        last_pop_next    = last_pop_reg;
        rsp_next         = rsp_reg;
        if (cmd.push)
        begin
            head_next = push_nh;
            if (push_drop)
                tail_next = next_ptr(tail_reg);
            rsp_next.out_key        = '0;
            rsp_next.out_pressed    = 1'b0;
            rsp_next.took_event     = 1'b0;
            rsp_next.dropped_oldest = push_drop;
            rsp_next.fill_level     = fill_of(head_next, tail_next);
        end
        else if (cmd.rd_finish)
        begin
            if (pop)
            begin
                tail_next     = next_ptr(tail_reg);
                cur_key_next  = rd_data_reg.key;
                cur_time_next = rd_data_reg.stamp;
                last_pop_next = now_reg;
            end
            cur_pressed_next        = new_pressed && !aged;
            rsp_next.out_key        = new_key;
            rsp_next.out_pressed    = new_pressed;
            rsp_next.took_event     = pop;
            rsp_next.dropped_oldest = 1'b0;
            rsp_next.fill_level     = fill_of(head_reg, tail_next);
        end
    end

    // Queue and current-key state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg        <= '0;
            tail_reg        <= '0;
            cur_key_reg     <= '0;
            cur_pressed_reg <= 1'b0;
            cur_time_reg    <= '0;
            last_pop_reg    <= '0;
        end
        else
        begin
            head_reg        <= head_next;
            tail_reg        <= tail_next;
            cur_key_reg     <= cur_key_next;
            cur_pressed_reg <= cur_pressed_next;
            cur_time_reg    <= cur_time_next;
            last_pop_reg    <= last_pop_next;
        end
    end

    // Hold read time and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.rd_start)
            now_reg <= req.now_ms;
        rsp_reg <= rsp_next;
    end

    assign rsp = rsp_reg;

endmodule

`default_nettype wire

// ===== hdl/key_event_fifo_with_paced_release.sv =====
// Key event queue with paced release.
//
// Channels: a command channel (start, busy, req) takes one item per transfer
// when start is high and busy is low. req.action selects a push of a key
// event or a read of the current key. Every item gives exactly one result on
// rsp, marked by done for one cycle; the receiver cannot stall, so a result
// must be taken in the cycle it appears.
// A separate write channel (cfg_valid, cfg_ready, cfg_index, cfg_data) sets
// the pacing registers; cfg_ready is always high. Write it while idle.
//
// Timing: a push gives its result in the cycle after the transfer and the block
// stays ready, so pushes run at one per cycle. A read raises busy for one
// cycle while the tail slot comes out of the ring memory's registered read
// port, then gives its registered result; the block takes no new item until
// busy drops again.
//
// Reset (rst_n, asynchronous) empties the ring, clears the current key to
// released and restores the register defaults. Ring contents are not cleared.
`default_nettype none

module key_event_fifo_with_paced_release (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire kefr_pkg::kefr_in_t               req,
    output logic                                  done,
    output kefr_pkg::kefr_out_t                   rsp,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [kefr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [kefr_pkg::CFG_DATA_W-1:0]  cfg_data
);

    kefr_pkg::kefr_cfg_t cfg;
    kefr_pkg::kefr_cmd_t cmd;

    kefr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    kefr_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (req.action),
        .busy   (busy),
        .done   (done),
        .cmd    (cmd)
    );

    kefr_dp u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .req   (req),
        .cfg   (cfg),
        .rsp   (rsp)
    );

endmodule

`default_nettype wire

// ===== hdl/kefr_checker.sv =====
`default_nettype none

module kefr_checker (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    input  wire logic                             busy,
    input  wire kefr_pkg::kefr_in_t               req,
    input  wire logic                             done,
    input  wire kefr_pkg::kefr_out_t              rsp
);

    // Read transfer holds the block busy for the next cycle
    a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (req.action == kefr_pkg::ACT_READ) |=> busy)
        else $error("read transfer did not raise busy");

    // Busy lasts a single cycle and ends with a result
    a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> done && !busy)
        else $error("busy read did not finish with a result");

    // Push transfer gives its result in the next cycle
    a_push_done: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (req.action == kefr_pkg::ACT_PUSH) |=> done && !busy)
        else $error("push transfer did not give a result");

    // A result comes only after a transfer or a busy cycle
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy) || ($past(start) && !$past(busy)))
        else $error("result without a transfer");

    // A result never both pops and drops
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(rsp.took_event && rsp.dropped_oldest))
        else $error("result both popped and dropped");

endmodule

bind key_event_fifo_with_paced_release kefr_checker u_kefr_checker (.*);

`default_nettype wire

// ===== verif/key_event_checker.sv =====
`timescale 1ns / 100ps

module key_event_checker
    import kefr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  kefr_in_t              req,
    input  logic                  done,
    input  kefr_out_t             rsp,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    errors,
    output int                    pending
);

    localparam int SHOWN_LIMIT = 10;

    // Shadow copy of the event ring
    logic [31:0] ring_key   [QUEUE_DEPTH];
    logic        ring_press [QUEUE_DEPTH];
    logic [31:0] ring_stamp [QUEUE_DEPTH];
    int unsigned wr_slot;
    int unsigned rd_slot;

    // Shadow copy of the current key and the pacing registers
    logic [31:0] held_key;
    logic        held_press;
    logic [31:0] held_stamp;
    logic [31:0] last_pop_ms;
    kefr_cfg_t   pacing;

    // Reports still owed by the block, oldest first
    kefr_out_t   key_report_q[$];

    // Apply one transfer to the shadow state and return the report it must give
    function automatic kefr_out_t advance_key_queue(input kefr_in_t item);
        kefr_out_t   rpt;
        int unsigned nxt;
        logic        fast_key;
        logic [31:0] gap_ms;
        logic [31:0] hold_ms;
        rpt = '0;
        if (item.action == ACT_PUSH)
        begin
            nxt = (wr_slot + 1) % QUEUE_DEPTH;
            // Full ring: drop the oldest event to make room
            if (nxt == rd_slot)
            begin
                rd_slot            = (rd_slot + 1) % QUEUE_DEPTH;
                rpt.dropped_oldest = 1'b1;
            end
            ring_key[wr_slot]   = item.key_code;
            ring_press[wr_slot] = item.key_pressed;
            ring_stamp[wr_slot] = item.now_ms;
            wr_slot             = nxt;
        end
        else
        begin
            // Classify on the key held before any pop
            fast_key = (held_key == pacing.backspace_code) ||
                       (held_key == pacing.delete_code);
            gap_ms   = fast_key ? {16'h0, pacing.read_gap_fast}
                                : {16'h0, pacing.read_gap_normal};
            hold_ms  = fast_key ? {16'h0, pacing.release_after_fast}
                                : {16'h0, pacing.release_after_normal};
            if ((!held_press || (item.now_ms - last_pop_ms) > gap_ms) &&
                wr_slot != rd_slot)
            begin
                held_key       = ring_key[rd_slot];
                held_press     = ring_press[rd_slot];
                held_stamp     = ring_stamp[rd_slot];
                rd_slot        = (rd_slot + 1) % QUEUE_DEPTH;
                last_pop_ms    = item.now_ms;
                rpt.took_event = 1'b1;
            end
            rpt.out_key     = held_key;
            rpt.out_pressed = held_press;
            // Auto-release a stale pressed key after reporting it
            if (held_press && (item.now_ms - held_stamp) > hold_ms)
                held_press = 1'b0;
        end
        rpt.fill_level = FILL_W'((wr_slot + QUEUE_DEPTH - rd_slot) % QUEUE_DEPTH);
        return rpt;
    endfunction

    // Count a bad report and show the first few
    task automatic flag_report(input string what, input kefr_out_t want, input kefr_out_t got);
        if (errors < SHOWN_LIMIT)
        begin
            $display("[%0t] %s: exp key=%h pr=%b took=%b drop=%b fill=%0d",
                     $realtime, what, want.out_key, want.out_pressed, want.took_event,
                     want.dropped_oldest, want.fill_level);
            $display("[%0t] %s: got key=%h pr=%b took=%b drop=%b fill=%0d",
                     $realtime, what, got.out_key, got.out_pressed, got.took_event,
                     got.dropped_oldest, got.fill_level);
        end
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        kefr_out_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < QUEUE_DEPTH; i++)
            begin
                ring_key[i]   = '0;
                ring_press[i] = 1'b0;
                ring_stamp[i] = '0;
            end
            wr_slot                     = 0;
            rd_slot                     = 0;
            held_key                    = '0;
            held_press                  = 1'b0;
            held_stamp                  = '0;
            last_pop_ms                 = '0;
            pacing.read_gap_normal      = GAP_NORMAL_RST;
            pacing.read_gap_fast        = GAP_FAST_RST;
            pacing.release_after_normal = REL_NORMAL_RST;
            pacing.release_after_fast   = REL_FAST_RST;
            pacing.backspace_code       = BACKSPACE_RST;
            pacing.delete_code          = DELETE_RST;
            key_report_q.delete();
            errors                      = 0;
            pending                     = 0;
        end
        else
        begin
            // Match a finished report against the oldest one owed
            if (done)
            begin
                if (key_report_q.size() == 0)
                    flag_report("report with nothing owed", '0, rsp);
                else
                begin
                    want = key_report_q.pop_front();
                    if (rsp.out_key !== want.out_key ||
                        rsp.out_pressed !== want.out_pressed ||
                        rsp.took_event !== want.took_event ||
                        rsp.dropped_oldest !== want.dropped_oldest ||
                        rsp.fill_level !== want.fill_level)
                        flag_report("report mismatch", want, rsp);
                end
            end

            // Track register writes; unknown indexes change nothing
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_READ_GAP_NORMAL:      pacing.read_gap_normal      = cfg_data[15:0];
                    CFG_READ_GAP_FAST:        pacing.read_gap_fast        = cfg_data[15:0];
                    CFG_RELEASE_AFTER_NORMAL: pacing.release_after_normal = cfg_data[15:0];
                    CFG_RELEASE_AFTER_FAST:   pacing.release_after_fast   = cfg_data[15:0];
                    CFG_BACKSPACE_CODE:       pacing.backspace_code       = cfg_data;
                    CFG_DELETE_CODE:          pacing.delete_code          = cfg_data;
                    default: ;
                endcase
            end

            // Predict the report of each accepted transfer
            if (start && !busy)
                key_report_q.push_back(advance_key_queue(req));

            pending = key_report_q.size();
        end
    end

endmodule

// ===== verif/tb_key_event_fifo_with_paced_release.sv =====
`timescale 1ns / 100ps

module tb_key_event_fifo_with_paced_release;
    import kefr_pkg::*;

    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 198;
    localparam int TOTAL_ITEMS  = 1600;
    localparam int MAX_GAP      = 30;
    localparam int STALL_LIMIT  = 2000;
    localparam int TAIL_CYCLES  = 8;

    // Indexes past the last register
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_IDX_W'(CFG_DELETE_CODE) + 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = CFG_IDX_W'(CFG_DELETE_CODE) + 2'd2;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  start     = 1'b0;
    kefr_in_t              req       = '0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  busy;
    logic                  done;
    logic                  cfg_ready;
    kefr_out_t             rsp;

    int                    errors;
    int                    pending;
    int                    items_sent  = 0;
    int                    quiet_cycles = 0;
    logic [31:0]           tick_ms;
    logic [31:0]           span_ms;
    logic [31:0]           stim_bs;
    logic [31:0]           stim_del;

    key_event_fifo_with_paced_release u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    key_event_checker u_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    always #5 clk = ~clk;

    // Abort when no transfer of any kind happens for too long
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic kefr_in_t key_item(input kefr_action_t act, input logic [31:0] code,
                                          input logic pressed, input logic [31:0] now);
        kefr_in_t item;
        item.action      = act;
        item.key_code    = code;
        item.key_pressed = pressed;
        item.now_ms      = now;
        return item;
    endfunction

    // Offer one item, idling first per the current schedule, and hold until transfer
    task automatic send_item(input kefr_in_t item);
        int   gap;
        int   idle_pct;
        logic free;
        if (items_sent < TOTAL_ITEMS / 3)
            idle_pct = 13;
        else if (items_sent < 2 * TOTAL_ITEMS / 3)
            idle_pct = 88;
        else
            idle_pct = 0;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        req   <= item;
        do
        begin
            @(negedge clk);
            free = !busy;
            @(posedge clk);
        end
        while (!free);
        items_sent++;
    endtask

    // Drop start and wait until every owed report has come back
    task automatic settle();
        start <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        logic free;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
        begin
            @(negedge clk);
            free = cfg_ready;
            @(posedge clk);
        end
        while (!free);
    endtask

    // Program all pacing registers; junk in the upper halves must be ignored
    task automatic load_pacing(input logic [15:0] gap_normal, input logic [15:0] gap_fast,
                               input logic [15:0] rel_normal, input logic [15:0] rel_fast,
                               input logic [31:0] bs_code, input logic [31:0] del_code);
        write_reg(CFG_READ_GAP_NORMAL,      {16'($urandom), gap_normal});
        write_reg(CFG_READ_GAP_FAST,        {16'($urandom), gap_fast});
        write_reg(CFG_RELEASE_AFTER_NORMAL, {16'($urandom), rel_normal});
        write_reg(CFG_RELEASE_AFTER_FAST,   {16'($urandom), rel_fast});
        write_reg(CFG_BACKSPACE_CODE,       bs_code);
        write_reg(CFG_DELETE_CODE,          del_code);
        // Writes past the last register must leave everything alone
        write_reg(CFG_SPARE_LO, $urandom);
        write_reg(CFG_SPARE_HI, $urandom);
        cfg_valid <= 1'b0;
        stim_bs  = bs_code;
        stim_del = del_code;
        span_ms  = {16'h0, gap_normal};
        if (gap_fast > span_ms)
            span_ms = {16'h0, gap_fast};
        if (rel_normal > span_ms)
            span_ms = {16'h0, rel_normal};
        if (rel_fast > span_ms)
            span_ms = {16'h0, rel_fast};
        span_ms = span_ms + 32'd2;
    endtask

    initial
    begin
        kefr_in_t item;
        int       push_pct;
        int       pick;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed pass on reset pacing: empty read, pacing and release edges, wrap
        send_item(key_item(ACT_READ, 32'd0,          1'b0, 32'd0));
        send_item(key_item(ACT_PUSH, 32'd65,         1'b1, 32'd100));
        send_item(key_item(ACT_PUSH, 32'd8,          1'b1, 32'd101));
        send_item(key_item(ACT_PUSH, 32'd127,        1'b1, 32'd102));
        send_item(key_item(ACT_PUSH, 32'hFFFF_FFFF,  1'b0, 32'd103));
        send_item(key_item(ACT_PUSH, 32'd0,          1'b1, 32'hFFFF_FFF0));
        send_item(key_item(ACT_READ, 32'hFFFF_FFFF,  1'b1, 32'd104));
        send_item(key_item(ACT_READ, 32'd0,          1'b0, 32'd114));
        send_item(key_item(ACT_READ, 32'd0,          1'b0, 32'd114));
        send_item(key_item(ACT_READ, 32'd0,          1'b0, 32'd115));
        send_item(key_item(ACT_READ, 32'd0,          1'b0, 32'd200));
        send_item(key_item(ACT_READ, 32'd0,          1'b0, 32'd201));
        send_item(key_item(ACT_READ, 32'd0,          1'b0, 32'd202));
        send_item(key_item(ACT_PUSH, 32'd8,          1'b1, 32'd300));
        send_item(key_item(ACT_READ, 32'd0,          1'b0, 32'd300));
        send_item(key_item(ACT_PUSH, 32'd65,         1'b1, 32'd301));
        send_item(key_item(ACT_READ, 32'd0,          1'b0, 32'd302));
        send_item(key_item(ACT_READ, 32'd0,          1'b0, 32'd303));
        send_item(key_item(ACT_READ, 32'd0,          1'b0, 32'd313));
        send_item(key_item(ACT_PUSH, 32'd5,          1'b1, 32'hFFFF_FFFE));
        send_item(key_item(ACT_READ, 32'd0,          1'b0, 32'd3));
        send_item(key_item(ACT_READ, 32'd0,          1'b0, 32'd12));
        settle();

        // Random phases, each under its own pacing setup
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: load_pacing(16'h0000, 16'h0000, 16'h0000, 16'h0000,
                               32'h0000_0000, 32'hFFFF_FFFF);
                1: load_pacing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, $urandom, $urandom);
                2: load_pacing(GAP_NORMAL_RST, GAP_FAST_RST, REL_NORMAL_RST, REL_FAST_RST,
                               BACKSPACE_RST, DELETE_RST);
                default: load_pacing(16'($urandom_range(0, 40)), 16'($urandom_range(0, 40)),
                                     16'($urandom_range(0, 40)), 16'($urandom_range(0, 40)),
                                     32'($urandom_range(0, 255)), $urandom);
            endcase
            // Odd phases start just short of the wrap point
            if (p % 2 == 1)
                tick_ms = 32'hFFFF_FFFF - 32'($urandom_range(0, 64)) * span_ms;
            else
                tick_ms = $urandom;
            push_pct = 50;

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // Shift the push/read mix every few dozen items to fill and drain
                if (n % 32 == 0)
                begin
                    pick = $urandom_range(2);
                    push_pct = (pick == 0) ? 20 : (pick == 1) ? 50 : 85;
                end
                item.action = ($urandom_range(99) < push_pct) ? ACT_PUSH : ACT_READ;
                pick = $urandom_range(99);
                if (pick < 30)
                    item.key_code = stim_bs;
                else if (pick < 60)
                    item.key_code = stim_del;
                else if (pick < 85)
                    item.key_code = 32'($urandom_range(0, 255));
                else
                    item.key_code = $urandom;
                item.key_pressed = ($urandom_range(99) < 70);
                tick_ms = tick_ms + 32'($urandom_range(0, span_ms));
                // Now and then a stray timestamp, often jumping backward
                item.now_ms = ($urandom_range(99) < 4) ? $urandom : tick_ms;
                send_item(item);
            end
            settle();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
